// ===== hdl/gbr_pkg.sv =====
// ---------------------------------------------------------------------------
// gbr_pkg
// Types, register indexes and the tap weight function shared by the blur.
// ---------------------------------------------------------------------------
package gbr_pkg;

   localparam int PIX_W  = 8;
   localparam int WT_W   = 33;   // product of two Q0.16 weights, center is 1.0
   localparam int PRD_W  = 41;   // weight times one channel
   localparam int ACC_W  = 46;   // up to 49 taps
   localparam int SCL_W  = 64;   // sum times reciprocal, Q.48
   localparam int IDX_W  = 3;
   localparam int DAT_W  = 17;

   localparam logic [IDX_W-1:0] REG_RADIUS = 3'd0;
   localparam logic [IDX_W-1:0] REG_W1     = 3'd1;
   localparam logic [IDX_W-1:0] REG_W2     = 3'd2;
   localparam logic [IDX_W-1:0] REG_W3     = 3'd3;
   localparam logic [IDX_W-1:0] REG_INV    = 3'd4;
   localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd5;
   localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd6;

   typedef struct packed {
      logic [1:0]  radius;
      logic [15:0] weight_one;
      logic [15:0] weight_two;
      logic [15:0] weight_three;
      logic [16:0] inv_sum;
      logic [10:0] width;
      logic [10:0] height;
      logic        restart;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic tap_start;
      logic tap_issue;
      logic scale_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic tap_last;
      logic pipe_empty;
      logic scale_last;
      logic out_free;
   } sts_type;

   function automatic logic [16:0] tap_weight(input logic [2:0] d,
                                              input logic [15:0] w1,
                                              input logic [15:0] w2,
                                              input logic [15:0] w3);
      logic [16:0] r;
      case (d)
         3'd0: r = 17'h10000;
         3'd1: r = {1'b0, w1};
         3'd2: r = {1'b0, w2};
         default: r = {1'b0, w3};
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/gbr_ram.sv =====
// ---------------------------------------------------------------------------
// gbr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module gbr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 7168
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/gbr_regs.sv =====
// ---------------------------------------------------------------------------
// gbr_regs
// Configuration registers; a write of geometry restarts the frame.
// ---------------------------------------------------------------------------
module gbr_regs
   import gbr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_fire,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DAT_W-1:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      cfg_in.restart = 1'b0;
      if (csr_fire) begin
         case (csr_index)
            REG_RADIUS: begin
               cfg_in.radius  = csr_data[1:0];
               cfg_in.restart = 1'b1;
            end
            REG_W1:  cfg_in.weight_one   = csr_data[15:0];
            REG_W2:  cfg_in.weight_two   = csr_data[15:0];
            REG_W3:  cfg_in.weight_three = csr_data[15:0];
            REG_INV: cfg_in.inv_sum      = csr_data;
            REG_WIDTH: begin
               cfg_in.width   = csr_data[10:0];
               cfg_in.restart = 1'b1;
            end
            REG_HEIGHT: begin
               cfg_in.height  = csr_data[10:0];
               cfg_in.restart = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius       <= 2'd1;
         cfg_ff.weight_one   <= 16'd64238;
         cfg_ff.weight_two   <= 16'd60498;
         cfg_ff.weight_three <= 16'd54744;
         cfg_ff.inv_sum      <= 17'd7478;
         cfg_ff.width        <= 11'd640;
         cfg_ff.height       <= 11'd480;
         cfg_ff.restart      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/gbr_ctrl.sv =====
// ---------------------------------------------------------------------------
// gbr_ctrl
// Sequencer: accept, tap sweep, pipeline drain, scaling, result hand-off.
// ---------------------------------------------------------------------------
module gbr_ctrl
   import gbr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    csr_valid,
   input  logic    csr_fire,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TAP   = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       settle_ff;

   assign req_ready = (state_ff == S_IDLE) && !csr_valid && !settle_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (sts.emit) begin
                  cmd.tap_start = 1'b1;
                  state_in      = S_TAP;
               end
            end
         end
         S_TAP: begin
            cmd.tap_issue = 1'b1;
            if (sts.tap_last) state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sts.pipe_empty) state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale_step = 1'b1;
            if (sts.scale_last) state_in = S_ROUND;
         end
         S_ROUND: state_in = S_OUT;
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         settle_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         // hold off items after a csr write so frame totals track the new registers
         settle_ff <= csr_fire;
      end
   end

endmodule

// ===== hdl/gbr_dp.sv =====
// ---------------------------------------------------------------------------
// gbr_dp
// Datapath: frame counters, row ring in RAM, tap address and weight
// generation, multiply-accumulate, scaling and the result register.
// ---------------------------------------------------------------------------
module gbr_dp
   import gbr_pkg::*;
#(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic             req_cmd,
   input  logic [PIX_W-1:0] req_red_in,
   input  logic [PIX_W-1:0] req_green_in,
   input  logic [PIX_W-1:0] req_blue_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_red_out,
   output logic [PIX_W-1:0] rsp_green_out,
   output logic [PIX_W-1:0] rsp_blue_out,
   output logic             rsp_frame_end
);

   // the input runs up to 2r rows ahead of the output row on narrow frames
   localparam int NROWS = 3 * MAX_RADIUS + 1;
   localparam int SW    = $clog2(NROWS);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int CW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int DW    = CW + 1;
   localparam int EW    = CW + 2;
   localparam int AW    = SW + XW;
   localparam int VW    = ((XW > YW) ? XW : YW) + 3;
   localparam int DEPTH = NROWS << XW;

   // effective geometry
   logic [RW-1:0] r_eff;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [SW-1:0] span;

   always_comb begin
      if (32'(cfg.radius) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
      else r_eff = RW'(cfg.radius);
      if (cfg.width == 11'd0) w_eff = WW'(1);
      else if (32'(cfg.width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(cfg.width);
      if (cfg.height == 11'd0) h_eff = HW'(1);
      else if (32'(cfg.height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(cfg.height);
      span = SW'({r_eff, 1'b0});
   end

   logic [CW-1:0] total_ff;
   logic [DW-1:0] delay_ff;

   always_ff @(posedge clock) begin
      total_ff <= CW'(w_eff) * CW'(h_eff);
      delay_ff <= DW'(r_eff) * DW'(w_eff) + DW'(r_eff);
   end

   // frame counters
   logic [CW-1:0] pin_ff, pin_in, oc_ff, oc_in;
   logic [DW-1:0] drain_ff, drain_in;
   logic [XW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SW-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [YW-1:0] out_row_ff, out_row_in;
   logic [YW-1:0] cur_row_ff;
   logic [XW-1:0] cur_col_ff;
   logic [SW-1:0] cur_slot_ff;
   logic          fe_pend_ff;
   logic          wr, dr, due, emit, last_px;
   logic [EW-1:0] have, need;

   always_comb begin
      wr       = !req_cmd && (pin_ff < total_ff);
      dr       = (pin_ff >= total_ff);
      have     = EW'(pin_ff) + EW'(wr) + EW'(drain_ff) + EW'(dr);
      need     = EW'(delay_ff) + EW'(oc_ff);
      due      = (wr || dr) && (have > need);
      emit     = due && (oc_ff < total_ff);
      last_px  = (oc_ff == total_ff - CW'(1));

      pin_in      = pin_ff;
      drain_in    = drain_ff;
      oc_in       = oc_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;

      if (cmd.accept) begin
         if (wr) begin
            pin_in = pin_ff + CW'(1);
            if ((WW + 1)'(in_col_ff) + (WW + 1)'(1) >= (WW + 1)'(w_eff)) begin
               in_col_in  = '0;
               in_slot_in = (in_slot_ff == SW'(NROWS - 1)) ? '0 : in_slot_ff + SW'(1);
            end else begin
               in_col_in = in_col_ff + XW'(1);
            end
         end
         if (dr) drain_in = drain_ff + DW'(1);
         if (emit) begin
            oc_in = oc_ff + CW'(1);
            if ((WW + 1)'(out_col_ff) + (WW + 1)'(1) >= (WW + 1)'(w_eff)) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + YW'(1);
               out_slot_in = (out_slot_ff == SW'(NROWS - 1)) ? '0
                                                             : out_slot_ff + SW'(1);
            end else begin
               out_col_in = out_col_ff + XW'(1);
            end
         end
      end

      // restart after the frame's last result, on an overrun, or on geometry writes
      if ((cmd.accept && due && (!emit || last_px)) || cfg.restart) begin
         pin_in      = '0;
         drain_in    = '0;
         oc_in       = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff      <= '0;
         drain_ff    <= '0;
         oc_ff       <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         pin_ff      <= pin_in;
         drain_ff    <= drain_in;
         oc_ff       <= oc_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emit) begin
         cur_row_ff  <= out_row_ff;
         cur_col_ff  <= out_col_ff;
         cur_slot_ff <= out_slot_ff;
         fe_pend_ff  <= last_px;
      end
   end

   // tap sweep
   logic [SW-1:0]        ti_ff, tj_ff;
   logic signed [VW-1:0] dy, dx, yv, xv, yoff, slot_s;
   logic [AW-1:0]        raddr;
   logic [2:0]           ady, adx;
   logic [16:0]          wy, wx;
   logic [23:0]          rdata;

   always_comb begin
      dy = $signed(VW'(ti_ff)) - $signed(VW'(r_eff));
      dx = $signed(VW'(tj_ff)) - $signed(VW'(r_eff));
      yv = $signed(VW'(cur_row_ff)) + dy;
      xv = $signed(VW'(cur_col_ff)) + dx;
      if (yv < 0) yv = '0;
      else if (yv >= $signed(VW'(h_eff))) yv = $signed(VW'(h_eff)) - VW'(1);
      if (xv < 0) xv = '0;
      else if (xv >= $signed(VW'(w_eff))) xv = $signed(VW'(w_eff)) - VW'(1);
      yoff   = yv - $signed(VW'(cur_row_ff));
      slot_s = $signed(VW'(cur_slot_ff)) + yoff;
      if (slot_s < 0) slot_s = slot_s + VW'(NROWS);
      else if (slot_s >= $signed(VW'(NROWS))) slot_s = slot_s - VW'(NROWS);
      raddr = {slot_s[SW-1:0], xv[XW-1:0]};
      ady   = 3'((dy < 0) ? -dy : dy);
      adx   = 3'((dx < 0) ? -dx : dx);
      wy    = tap_weight(ady, cfg.weight_one, cfg.weight_two, cfg.weight_three);
      wx    = tap_weight(adx, cfg.weight_one, cfg.weight_two, cfg.weight_three);
   end

   gbr_ram #(
      .WIDTH(24),
      .DEPTH(DEPTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (cmd.accept && wr),
      .wr_addr({in_slot_ff, in_col_ff}),
      .wr_data({req_blue_in, req_green_in, req_red_in}),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   // multiply-accumulate pipeline
   logic [WT_W-1:0]  wt_ff;
   logic             v1_ff, v2_ff;
   logic [PRD_W-1:0] prod_ff [3];
   logic [ACC_W-1:0] acc_ff  [3];
   logic [1:0]       sidx_ff, sd_ff;
   logic             sv_ff;
   logic [SCL_W-1:0] sp_ff, rnd;
   logic [PIX_W-1:0] res_ff [3];
   logic [PIX_W-1:0] rval;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_issue;
         v2_ff <= v1_ff;
         sv_ff <= cmd.scale_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tap_issue) begin
         ti_ff <= (tj_ff == span) ? ti_ff + SW'(1) : ti_ff;
         tj_ff <= (tj_ff == span) ? '0 : tj_ff + SW'(1);
      end
      if (cmd.tap_start) begin
         ti_ff <= '0;
         tj_ff <= '0;
      end
      wt_ff <= WT_W'(wy) * WT_W'(wx);
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= PRD_W'(wt_ff) * PRD_W'(rdata[c*PIX_W +: PIX_W]);
         if (cmd.tap_start) acc_ff[c] <= '0;
         else if (v2_ff) acc_ff[c] <= acc_ff[c] + ACC_W'(prod_ff[c]);
      end
      if (cmd.tap_start) sidx_ff <= '0;
      else if (cmd.scale_step) sidx_ff <= sidx_ff + 2'd1;
      sp_ff <= SCL_W'(acc_ff[sidx_ff]) * SCL_W'(cfg.inv_sum);
      sd_ff <= sidx_ff;
      if (sv_ff) res_ff[sd_ff] <= rval;
   end

   always_comb begin
      rnd  = sp_ff + (SCL_W'(1) << 47);
      rval = (rnd[SCL_W-1:48] > 16'd255) ? 8'hFF : rnd[55:48];
   end

   // result register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic             rsp_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_r_ff  <= res_ff[0];
         rsp_g_ff  <= res_ff[1];
         rsp_b_ff  <= res_ff[2];
         rsp_fe_ff <= fe_pend_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_r_ff;
   assign rsp_green_out = rsp_g_ff;
   assign rsp_blue_out  = rsp_b_ff;
   assign rsp_frame_end = rsp_fe_ff;

   always_comb begin
      sts.emit       = emit;
      sts.tap_last   = (ti_ff == span) && (tj_ff == span);
      sts.pipe_empty = !v1_ff && !v2_ff;
      sts.scale_last = (sidx_ff == 2'd2);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ===== hdl/gaussian_blur_replicate_border.sv =====
// ---------------------------------------------------------------------------
// gaussian_blur_replicate_border
// Streaming RGB Gaussian blur, square window 2r+1, replicated frame edges.
//
//   channel  direction  beat contents
//   req      in         cmd, red_in, green_in, blue_in
//   rsp      out        red_out, green_out, blue_out, frame_end
//   csr      in         index, data (register write)
//
// A beat with no result leaves the block ready for the next req beat. A beat
// with a result holds off the next req beat while the block accepts it, reads
// each tap in turn through the single read port of the line memory, empties
// the multiply pipe, scales, rounds and loads rsp once it is free. Synchronous
// reset returns to the reset registers and an empty frame. A stalled rsp
// holds one finished result while the next beat is taken; the cycle after a
// csr write takes no req beat.
// ---------------------------------------------------------------------------
module gaussian_blur_replicate_border
   import gbr_pkg::*;
#(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cmd,
   input  logic [PIX_W-1:0] req_red_in,
   input  logic [PIX_W-1:0] req_green_in,
   input  logic [PIX_W-1:0] req_blue_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_red_out,
   output logic [PIX_W-1:0] rsp_green_out,
   output logic [PIX_W-1:0] rsp_blue_out,
   output logic             rsp_frame_end,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DAT_W-1:0] csr_data
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   gbr_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_fire (csr_fire),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cfg      (cfg)
   );

   gbr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .csr_valid(csr_valid),
      .csr_fire (csr_fire),
      .sts      (sts),
      .cmd      (cmd)
   );

   gbr_dp #(
      .MAX_RADIUS(MAX_RADIUS),
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .sts          (sts),
      .req_cmd      (req_cmd),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .rsp_frame_end(rsp_frame_end)
   );

endmodule

// ===== tb/gaussian_blur_replicate_border_checker.sv =====
// ---------------------------------------------------------------------------
// gaussian_blur_replicate_border_checker
// Watches the req, rsp and csr channels of the blur and keeps its own copy of
// the registers, the frame store and the frame counters. Each req beat is
// turned into the blurred pixel it should release, if any. Each rsp beat is
// compared field by field with the oldest pixel still owed.
// ---------------------------------------------------------------------------
module gaussian_blur_replicate_border_checker
   import gbr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_cmd,
   input  logic [PIX_W-1:0] req_red_in,
   input  logic [PIX_W-1:0] req_green_in,
   input  logic [PIX_W-1:0] req_blue_in,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [PIX_W-1:0] rsp_red_out,
   input  logic [PIX_W-1:0] rsp_green_out,
   input  logic [PIX_W-1:0] rsp_blue_out,
   input  logic             rsp_frame_end,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DAT_W-1:0] csr_data,
   output int               fail_count,
   output int               owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIMIT_RADIUS = 3;
   localparam int unsigned LIMIT_WIDTH  = 1024;
   localparam int unsigned LIMIT_HEIGHT = 1024;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_pixel_type;

   logic [1:0]  radius_q;
   logic [15:0] gain_one, gain_two, gain_three;
   logic [16:0] inv_sum_q;
   logic [10:0] width_q, height_q;
   int unsigned in_row, in_col, out_cnt, drain_cnt;
   logic [23:0] frame_mem [int unsigned];
   blur_pixel_type owed_pixels [$];

   assign owed_count = owed_pixels.size();

   function automatic logic [16:0] tap_gain(int unsigned d);
      case (d)
         0: return 17'h10000;
         1: return {1'b0, gain_one};
         2: return {1'b0, gain_two};
         default: return {1'b0, gain_three};
      endcase
   endfunction

   function automatic int clip(int v, int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
      fail_count++;
   endtask

   task automatic restart_frame();
      in_row = 0;
      in_col = 0;
      out_cnt = 0;
      drain_cnt = 0;
   endtask

   task automatic predict_blur(logic cmd, logic [23:0] rgb);
      int unsigned w, h, rad, total, delay, pin, k, row, col;
      int dy, dx, y, x;
      logic [63:0] acc [3];
      logic [63:0] wt, v;
      logic [23:0] px;
      blur_pixel_type e;
      w = (width_q == 0) ? 1 : ((width_q > LIMIT_WIDTH) ? LIMIT_WIDTH : width_q);
      h = (height_q == 0) ? 1 : ((height_q > LIMIT_HEIGHT) ? LIMIT_HEIGHT : height_q);
      rad = (radius_q > LIMIT_RADIUS) ? LIMIT_RADIUS : radius_q;
      total = w * h;
      delay = rad * w + rad;
      pin = in_row * w + in_col;
      if (pin > total) pin = total;
      if (!cmd && pin < total) begin
         frame_mem[pin] = rgb;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         pin++;
      end else if (pin >= total) begin
         drain_cnt++;
      end else begin
         return;   // early flush: drop
      end
      if (pin + drain_cnt <= delay + out_cnt) return;
      k = out_cnt;
      if (k >= total) begin
         restart_frame();
         return;
      end
      row = k / w;
      col = k % w;
      for (int c = 0; c < 3; c++) acc[c] = '0;
      for (dy = -int'(rad); dy <= int'(rad); dy++) begin
         y = clip(int'(row) + dy, int'(h));
         for (dx = -int'(rad); dx <= int'(rad); dx++) begin
            x = clip(int'(col) + dx, int'(w));
            wt = 64'(tap_gain(dy < 0 ? -dy : dy)) * 64'(tap_gain(dx < 0 ? -dx : dx));
            px = frame_mem[y * w + x];
            for (int c = 0; c < 3; c++) acc[c] += wt * 64'(px[8*c +: 8]);
         end
      end
      for (int c = 0; c < 3; c++) begin
         v = (acc[c] * 64'(inv_sum_q) + (64'd1 << 47)) >> 48;
         px[8*c +: 8] = (v > 255) ? 8'd255 : v[7:0];
      end
      e.red = px[7:0];
      e.green = px[15:8];
      e.blue = px[23:16];
      e.frame_end = (k == total - 1);
      out_cnt = k + 1;
      if (e.frame_end) restart_frame();
      owed_pixels.push_back(e);
   endtask

   always @(posedge clock) begin
      blur_pixel_type e;
      if (reset) begin
         radius_q = 2'd1;
         gain_one = 16'd64238;
         gain_two = 16'd60498;
         gain_three = 16'd54744;
         inv_sum_q = 17'd7478;
         width_q = 11'd640;
         height_q = 11'd480;
         restart_frame();
         owed_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_pixels.size() == 0) begin
               report_mismatch("unexpected rsp beat, owed pixels", 0, 1);
            end else begin
               e = owed_pixels.pop_front();
               if (rsp_red_out !== e.red) report_mismatch("red_out", e.red, rsp_red_out);
               if (rsp_green_out !== e.green)
                  report_mismatch("green_out", e.green, rsp_green_out);
               if (rsp_blue_out !== e.blue) report_mismatch("blue_out", e.blue, rsp_blue_out);
               if (rsp_frame_end !== e.frame_end)
                  report_mismatch("frame_end", e.frame_end, rsp_frame_end);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RADIUS: begin radius_q = csr_data[1:0]; restart_frame(); end
               REG_W1:     gain_one = csr_data[15:0];
               REG_W2:     gain_two = csr_data[15:0];
               REG_W3:     gain_three = csr_data[15:0];
               REG_INV:    inv_sum_q = csr_data[16:0];
               REG_WIDTH:  begin width_q = csr_data[10:0]; restart_frame(); end
               REG_HEIGHT: begin height_q = csr_data[10:0]; restart_frame(); end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_blur(req_cmd, {req_blue_in, req_green_in, req_red_in});
      end
   end

   initial fail_count = 0;

endmodule

// ===== tb/gaussian_blur_replicate_border_tb.sv =====
// ---------------------------------------------------------------------------
// gaussian_blur_replicate_border_tb
// Drives frames of pixels and drain flushes into the blur under a series of
// register settings, with random gaps on both channels, and gives the verdict
// from the checker's failure count.
// ---------------------------------------------------------------------------
module gaussian_blur_replicate_border_tb;
   import gbr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE = 80;
   localparam int ITEM_GOAL = 1650;
   localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

   logic             clock, reset;
   logic             req_valid, req_ready, req_cmd;
   logic [PIX_W-1:0] req_red_in, req_green_in, req_blue_in;
   logic             rsp_valid, rsp_ready, rsp_frame_end;
   logic [PIX_W-1:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic             csr_valid, csr_ready;
   logic [IDX_W-1:0] csr_index;
   logic [DAT_W-1:0] csr_data;
   int               fail_count, owed_count;

   int send_idle, recv_stall;
   int hold_asked, hold_seen;
   int items_sent, idle_cycles;
   int unsigned fw, fh, fr;   // effective frame geometry

   gaussian_blur_replicate_border u_dut (.*);

   gaussian_blur_replicate_border_checker u_checker (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("gaussian_blur_replicate_border regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // hold input until every owed pixel is out, then let the pipe settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (owed_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_RADIUS: fr = data[1:0];
         REG_WIDTH:  fw = (data[10:0] == 0) ? 1 : ((data[10:0] > 1024) ? 1024 : data[10:0]);
         REG_HEIGHT: fh = (data[10:0] == 0) ? 1 : ((data[10:0] > 1024) ? 1024 : data[10:0]);
         default: ;
      endcase
   endtask

   function automatic logic [7:0] chan_value(int style);
      case (style)
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one frame: pixels, then enough flushes to drain it; optional noise
   task automatic send_frame(int style, bit noisy, bit stray_pixel);
      int unsigned n;
      n = fw * fh;
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(9) == 0) put_beat(1'b1, 8'h5a, 8'ha5, 8'h3c);
         put_beat(1'b0, chan_value(style == 3 ? $urandom_range(2) : style),
                  chan_value(style == 3 ? $urandom_range(2) : style),
                  chan_value(style == 3 ? $urandom_range(2) : style));
      end
      for (int unsigned i = 0; i <= fr * fw + fr; i++) begin
         if (stray_pixel && i == 0) put_beat(1'b0, 8'hff, 8'h00, 8'hff);
         else put_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int cut;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle = 9;
      recv_stall = 83;
      hold_asked = 0;
      items_sent = 0;
      fw = 640; fh = 480; fr = 1;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed: extreme weights, odd registers, early flush, stray pixel
      write_reg(REG_RADIUS, 17'd3);
      write_reg(REG_W1, 17'hffff);
      write_reg(REG_W2, 17'd0);
      write_reg(REG_W3, 17'hffff);
      write_reg(REG_INV, 17'd65536);
      write_reg(REG_WIDTH, 17'd3);
      write_reg(REG_HEIGHT, 17'd2);
      write_reg(REG_NONE, 17'h1ffff);
      put_beat(1'b1, 8'd0, 8'd0, 8'd0);
      send_frame(1, 1'b0, 1'b1);
      wait_drain();
      write_reg(REG_INV, 17'd0);
      write_reg(REG_RADIUS, 17'd0);
      write_reg(REG_WIDTH, 17'd0);
      write_reg(REG_HEIGHT, 17'd0);
      send_frame(2, 1'b0, 1'b0);
      wait_drain();
      write_reg(REG_INV, 17'd4096);
      write_reg(REG_W1, 17'h1aaaa);
      write_reg(REG_W2, 17'h05555);
      write_reg(REG_W3, 17'h1a5a5);
      write_reg(REG_RADIUS, 17'd1);
      write_reg(REG_WIDTH, 17'd2);
      write_reg(REG_HEIGHT, 17'd2);
      send_frame(0, 1'b0, 1'b0);
      send_frame(3, 1'b0, 1'b0);
      wait_drain();

      // widest frame, saturated width, single row
      write_reg(REG_RADIUS, 17'd0);
      write_reg(REG_WIDTH, 17'd2047);
      write_reg(REG_HEIGHT, 17'd1);
      write_reg(REG_INV, 17'd65536);
      send_frame(2, 1'b0, 1'b0);
      wait_drain();

      while (items_sent < ITEM_GOAL || send_idle != 0 || hold_asked == 0) begin
         if (items_sent >= 1300 && send_idle == 9) begin
            send_idle = 83;
            recv_stall = 9;
         end else if (items_sent >= 1300 + 200 && send_idle == 83) begin
            send_idle = 0;
            recv_stall = 0;
         end
         wait_drain();
         write_reg(REG_RADIUS, 17'($urandom_range(3)));
         write_reg(REG_W1, 17'($urandom));
         write_reg(REG_W2, 17'($urandom));
         write_reg(REG_W3, 17'($urandom));
         write_reg(REG_INV, ($urandom_range(3) == 0) ? 17'($urandom_range(65536))
                                                     : 17'($urandom_range(9000)));
         write_reg(REG_WIDTH, 17'($urandom_range(12, 1)));
         write_reg(REG_HEIGHT, 17'($urandom_range(8, 1)));
         if ($urandom_range(9) == 0) begin
            // broken frame: stop partway, then restart it by a width write
            cut = $urandom_range(fw * fh);
            for (int i = 0; i < cut; i++)
               put_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
            wait_drain();
            write_reg(REG_WIDTH, 17'(fw));
         end
         if (send_idle == 0 && hold_asked == 0) begin
            hold_asked = 1;   // long rsp hold-off while pixels keep coming
            send_idle = 0;
         end
         send_frame(3, $urandom_range(1), $urandom_range(7) == 0);
         if ($urandom_range(1)) send_frame(2, 1'b0, 1'b0);
      end

      wait_drain();
      if (fail_count == 0) begin
         $display("gaussian_blur_replicate_border regression: pass");
      end else begin
         $display("gaussian_blur_replicate_border regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/gbr_pkg.sv
hdl/gbr_ram.sv
hdl/gbr_regs.sv
hdl/gbr_ctrl.sv
hdl/gbr_dp.sv
hdl/gaussian_blur_replicate_border.sv
tb/gaussian_blur_replicate_border_checker.sv
tb/gaussian_blur_replicate_border_tb.sv
